@@ rtl/hsdd_pkg.sv @@
// shared types and constants for the hash set duplicate detector
package hsdd_pkg;

  localparam int HSDD_BUCKETS = 256;
  localparam int HSDD_WAYS    = 4;

  // bucket rows carry an epoch tag so that an array end clears the set at once
  localparam int EPOCH_W = 8;

  // low words of the mixer multipliers: only the low 32 product bits are kept
  localparam logic [31:0] MIX_MUL_A_LO = 32'h1ce4e5b9;
  localparam logic [31:0] MIX_MUL_B_LO = 32'h133111eb;
  localparam int MIX_SH_0 = 30;
  localparam int MIX_SH_1 = 27;
  localparam int MIX_SH_2 = 31;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_item;
  } hsdd_in_t;

  typedef struct packed {
    logic seen_before;
    logic any_duplicate;
    logic bucket_overflow;
    logic end_of_array;
  } hsdd_out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clr;
    logic h1;
    logic h2;
    logic h3;
    logic h4;
    logic rd;
    logic upd;
  } hsdd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic epoch_full;
    logic last;
  } hsdd_stat_t;

endpackage

@@ rtl/hsdd_ctrl.sv @@
// sequencer for the duplicate detector: clear pass, hash steps, bucket read and update
module hsdd_ctrl
  import hsdd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  hsdd_stat_t stat,
  output hsdd_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CLEAR = 8'b0000_0010,
    ST_H1    = 8'b0000_0100,
    ST_H2    = 8'b0000_1000,
    ST_H3    = 8'b0001_0000,
    ST_H4    = 8'b0010_0000,
    ST_RD    = 8'b0100_0000,
    ST_UPD   = 8'b1000_0000
  } hsdd_state_t;

  hsdd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_H1;
      end
      ST_CLEAR: begin
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_H1: state_nxt = ST_H2;
      ST_H2: state_nxt = ST_H3;
      ST_H3: state_nxt = ST_H4;
      ST_H4: state_nxt = ST_RD;
      ST_RD: state_nxt = ST_UPD;
      ST_UPD: begin
        // epoch tag runs out at this array end: wipe all rows first
        if (stat.last && stat.epoch_full) state_nxt = ST_CLEAR;
        else                              state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign busy       = (state_r != ST_IDLE);
  assign cmd.accept = (state_r == ST_IDLE) && start;
  assign cmd.clr    = (state_r == ST_CLEAR);
  assign cmd.h1     = (state_r == ST_H1);
  assign cmd.h2     = (state_r == ST_H2);
  assign cmd.h3     = (state_r == ST_H3);
  assign cmd.h4     = (state_r == ST_H4);
  assign cmd.rd     = (state_r == ST_RD);
  assign cmd.upd    = (state_r == ST_UPD);

endmodule

@@ rtl/hsdd_dp.sv @@
// datapath: mixer, bucket reduction, bucket row memory and set update
module hsdd_dp
  import hsdd_pkg::*;
#(
  parameter int BUCKETS = HSDD_BUCKETS,
  parameter int WAYS    = HSDD_WAYS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  hsdd_cmd_t  cmd,
  input  hsdd_in_t   in_item,
  output hsdd_stat_t stat,
  output logic       out_valid,
  output hsdd_out_t  out_result
);

  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int KEYS_W = 32 * WAYS;
  localparam int ROW_W  = EPOCH_W + WAYS + KEYS_W;
  localparam int SHIFT  = 32 + BKT_W;
  // reciprocal of the bucket count; the quotient estimate is low by at most one
  localparam logic [32:0]    RECIP   = 33'((65'd1 << SHIFT) / BUCKETS);
  localparam logic [BKT_W:0] BKT_CNT = (BKT_W + 1)'(BUCKETS);
  localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);

  logic [31:0]        val_r;
  logic               last_r;
  logic [31:0]        m1_r;
  logic [31:0]        m2_r;
  logic [31:0]        h_r;
  logic [64:0]        prod_r;
  logic [31:0]        qb_r;
  logic [BKT_W-1:0]   bkt_r;
  logic [BKT_W-1:0]   clr_idx_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic               dup_r;
  logic               out_valid_r;
  hsdd_out_t          out_result_r;
  logic [ROW_W-1:0]   rd_data_r;
  logic [ROW_W-1:0]   mem [BUCKETS];

  logic [31:0]        x0, x1, x2;
  logic [31:0]        q_est;
  logic [31:0]        rem;
  logic [BKT_W-1:0]   bkt;
  logic [EPOCH_W-1:0] row_epoch;
  logic [WAYS-1:0]    row_mask;
  logic [WAYS-1:0]    mask;
  logic [WAYS-1:0]    match;
  logic [WAYS-1:0]    free_oh;
  logic [KEYS_W-1:0]  new_keys;
  logic               hit;
  logic               full;
  logic               store;
  logic               wr_en;
  logic [BKT_W-1:0]   wr_addr;
  logic [ROW_W-1:0]   wr_data;

  // mixer rounds: xor with arithmetic shift; the first two then take a low-word multiply
  assign x0 = val_r ^ 32'($signed(val_r) >>> MIX_SH_0);
  assign x1 = m1_r ^ 32'($signed(m1_r) >>> MIX_SH_1);
  assign x2 = m2_r ^ 32'($signed(m2_r) >>> MIX_SH_2);

  assign q_est = 32'(prod_r >> SHIFT);
  assign rem   = h_r - qb_r;
  assign bkt   = (rem >= 32'(BKT_CNT)) ? BKT_W'(rem - 32'(BKT_CNT)) : BKT_W'(rem);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_r  <= in_item.value;
      last_r <= in_item.last_item;
    end
    if (cmd.h1) m1_r <= 32'(x0 * MIX_MUL_A_LO);
    if (cmd.h2) m2_r <= 32'(x1 * MIX_MUL_B_LO);
    if (cmd.h3) begin
      h_r    <= x2;
      prod_r <= 65'(x2 * RECIP);
    end
    if (cmd.h4) qb_r  <= 32'(q_est * BKT_CNT);
    if (cmd.rd) bkt_r <= bkt;
  end

  // bucket row: {epoch, valid mask, keys}; a row of an older epoch reads as empty
  assign row_epoch = rd_data_r[KEYS_W + WAYS +: EPOCH_W];
  assign row_mask  = rd_data_r[KEYS_W +: WAYS];
  assign mask      = (row_epoch == epoch_r) ? row_mask : '0;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = mask[w] && (rd_data_r[w*32 +: 32] == val_r);
    end
  end

  assign hit     = |match;
  assign full    = &mask;
  assign free_oh = ~mask & (mask + WAYS'(1));
  assign store   = cmd.upd && !hit && !full;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      new_keys[w*32 +: 32] = free_oh[w] ? val_r : rd_data_r[w*32 +: 32];
    end
  end

  assign wr_en   = cmd.clr || store;
  assign wr_addr = cmd.clr ? clr_idx_r : bkt_r;
  assign wr_data = cmd.clr ? {epoch_r, {WAYS{1'b0}}, {KEYS_W{1'b0}}}
                           : {epoch_r, mask | free_oh, new_keys};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rd_data_r <= mem[bkt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      epoch_r     <= '0;
      dup_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.upd;
      if (cmd.clr) begin
        clr_idx_r <= (clr_idx_r == BKT_LAST) ? '0 : clr_idx_r + BKT_W'(1);
      end
      if (cmd.upd) begin
        if (last_r) begin
          dup_r   <= 1'b0;
          epoch_r <= epoch_r + EPOCH_W'(1);
        end else if (hit) begin
          dup_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_result_r.seen_before     <= hit;
      out_result_r.any_duplicate   <= dup_r | hit;
      out_result_r.bucket_overflow <= !hit && full;
      out_result_r.end_of_array    <= last_r;
    end
  end

  assign stat.clr_done   = (clr_idx_r == BKT_LAST);
  assign stat.epoch_full = (epoch_r == {EPOCH_W{1'b1}});
  assign stat.last       = last_r;
  assign out_valid       = out_valid_r;
  assign out_result      = out_result_r;

endmodule

@@ rtl/hash_set_duplicate_detector.sv @@
// top level of the hash set duplicate detector
//
// Input: a request is taken at a clock edge where start is high and busy is
// low; in_item carries the signed value and last_item, which closes an array.
// Output: one result per request, shown for exactly one cycle with out_valid
// high; the receiver cannot stall, so it must take every result as it comes.
// One request is worked on at a time, so a new one is taken only once the
// last is through: the mixer and bucket reduction steps (one multiplier
// each), one bucket row read and one read-modify-write of that row; the
// result is registered from that write step.
// Each bucket row holds all its ways, a valid mask and an epoch tag; the end
// of an array bumps the epoch, which empties the set at once.
// Reset: a clearing pass writes every bucket row, with busy high. The same
// pass runs at the end of every 2**EPOCH_W-th array, when the epoch tag
// wraps; the duplicate flag clears with the array end.
module hash_set_duplicate_detector
  import hsdd_pkg::*;
#(
  parameter int BUCKETS = HSDD_BUCKETS,
  parameter int WAYS    = HSDD_WAYS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  hsdd_in_t  in_item,
  output logic      out_valid,
  output hsdd_out_t out_result
);

  hsdd_cmd_t  cmd;
  hsdd_stat_t stat;

  hsdd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  hsdd_dp #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (in_item),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  // a value already in the set is never also reported as dropped
  a_seen_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_result.seen_before && out_result.bucket_overflow))
    else $error("seen_before and bucket_overflow both set");

  // the sticky flag covers the current request
  a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.seen_before |-> out_result.any_duplicate)
    else $error("duplicate not reflected in any_duplicate");

  // a taken request keeps the block busy until its result is out
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  // results never come back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid high for two cycles");

endmodule
